[rtl/core/horspool_substring_search_defines.svh]
// Assertion macros used by the substring search top level.
// Needs no other file; include it by its bare name.
`ifndef HORSPOOL_SUBSTRING_SEARCH_DEFINES_SVH
`define HORSPOOL_SUBSTRING_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HSS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hss_pkg.sv]
// Shared constants for the substring search block.
// No dependencies; used by the top level.
package hss_pkg;

  localparam int DEF_MAX_PATTERN = 64;
  localparam int DEF_MAX_TEXT    = 4096;

  localparam int BYTE_W   = 8;
  localparam int ALPHABET = 256;
  localparam int POS_W    = 12;
  localparam int ACT_W    = 2;

  localparam logic [ACT_W-1:0] ACT_PATTERN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TEXT    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH  = 2'd2;

endpackage

[rtl/core/hss_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; no package needed.
module hss_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/horspool_substring_search.sv]
// Top level of the Horspool substring search: sequencer, counters, result register.
// Depends on hss_pkg, hss_ram and horspool_substring_search_defines.svh.
//
//   channel | signals                              | moves
//   in      | in_valid, in_ready, action, data_byte | load byte or search request
//   out     | out_valid, out_ready, found, position, overflow | search result
//
// A load request is taken even while a result waits.
// A search presets the skip table (one entry a cycle, single write port), builds
// it from every pattern byte but the last, compares window bytes from the end,
// shifts the window by the skip entry of its last byte and posts the result.
// Empty pattern or pattern longer than text: straight to posting the result.
// in_ready is low during a search; a result holds until out_ready.
// Reset clears counts, flag and control; the stores are not cleared.
`include "horspool_substring_search_defines.svh"

module horspool_substring_search #(
  parameter int MAX_PATTERN = hss_pkg::DEF_MAX_PATTERN,
  parameter int MAX_TEXT    = hss_pkg::DEF_MAX_TEXT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hss_pkg::ACT_W-1:0]  action,
  input  logic [hss_pkg::BYTE_W-1:0] data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       found,
  output logic [hss_pkg::POS_W-1:0]  position,
  output logic                       overflow
);

  localparam int PCW  = $clog2(MAX_PATTERN + 1);
  localparam int PAW  = $clog2(MAX_PATTERN);
  localparam int TCW  = $clog2(MAX_TEXT + 1);
  localparam int TAW  = $clog2(MAX_TEXT);
  localparam int SW   = ((TCW > PCW) ? TCW : PCW) + 1;
  localparam int IDXW = $clog2(hss_pkg::ALPHABET);
  localparam int BW   = hss_pkg::BYTE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_BLD_RD, S_BLD_WR, S_CMP_RD, S_CMP_CHK,
    S_SKP_RD, S_SKP_LK, S_SKP_ADV, S_DONE
  } state_t;

  state_t          state;
  logic [PCW-1:0]  pat_cnt;
  logic [TCW-1:0]  txt_cnt;
  logic            ovf_flag;
  logic [IDXW-1:0] idx;
  logic [PCW-1:0]  k;
  logic [SW-1:0]   at;
  logic            res_found;

  logic            in_fire, pat_room, txt_room, out_free;
  logic            pat_we, txt_we, skp_we;
  logic [PAW-1:0]  pat_raddr;
  logic [TAW-1:0]  txt_raddr;
  logic [BW-1:0]   pat_rdata, txt_rdata;
  logic [IDXW-1:0] skp_waddr;
  logic [PCW-1:0]  skp_wdata, skp_rdata, k_dec;
  logic [SW-1:0]   m_sw, n_sw, txt_off, txt_addr_full, at_adv;
  logic            bld_more, adv_ok;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pat_room = pat_cnt < PCW'(MAX_PATTERN);
  assign txt_room = txt_cnt < TCW'(MAX_TEXT);

  assign pat_we = in_fire && (action == hss_pkg::ACT_PATTERN) && pat_room;
  assign txt_we = in_fire && (action == hss_pkg::ACT_TEXT) && txt_room;

  assign m_sw = SW'(pat_cnt);
  assign n_sw = SW'(txt_cnt);

  // Text reads: compare byte at + k - 1, or last window byte at + m - 1.
  assign txt_off       = (state == S_SKP_RD) ? m_sw : SW'(k);
  assign txt_addr_full = at + txt_off - SW'(1);
  assign txt_raddr     = txt_addr_full[TAW-1:0];

  assign k_dec     = k - PCW'(1);
  assign pat_raddr = (state == S_BLD_RD) ? PAW'(idx) : k_dec[PAW-1:0];

  // Preset every entry to m, then entry for pattern[i] gets m - 1 - i.
  assign skp_we    = (state == S_FILL) || (state == S_BLD_WR);
  assign skp_waddr = (state == S_FILL) ? idx : pat_rdata;
  assign skp_wdata = (state == S_FILL) ? pat_cnt : (pat_cnt - PCW'(1) - PCW'(idx));

  assign bld_more = ((IDXW + 1)'(idx) + (IDXW + 1)'(2)) < (IDXW + 1)'(pat_cnt);
  assign at_adv   = at + SW'(skp_rdata);
  assign adv_ok   = (at_adv + m_sw) <= n_sw;

  hss_ram #(.DEPTH(MAX_PATTERN), .WIDTH(BW)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_cnt[PAW-1:0]),
    .wdata (data_byte),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  hss_ram #(.DEPTH(MAX_TEXT), .WIDTH(BW)) u_txt_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (txt_cnt[TAW-1:0]),
    .wdata (data_byte),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

  hss_ram #(.DEPTH(hss_pkg::ALPHABET), .WIDTH(PCW)) u_skp_ram (
    .clk   (clk),
    .we    (skp_we),
    .waddr (skp_waddr),
    .wdata (skp_wdata),
    .raddr (txt_rdata),
    .rdata (skp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pat_cnt   <= '0;
      txt_cnt   <= '0;
      ovf_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // S_DONE reloads the result register itself when it is taken.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (action)
              hss_pkg::ACT_PATTERN: begin
                if (pat_room) pat_cnt <= pat_cnt + PCW'(1);
                else ovf_flag <= 1'b1;
              end
              hss_pkg::ACT_TEXT: begin
                if (txt_room) txt_cnt <= txt_cnt + TCW'(1);
                else ovf_flag <= 1'b1;
              end
              hss_pkg::ACT_SEARCH: begin
                idx <= '0;
                at  <= '0;
                k   <= pat_cnt;
                if (pat_cnt == '0) begin
                  res_found <= 1'b1;
                  state     <= S_DONE;
                end else if (m_sw > n_sw) begin
                  res_found <= 1'b0;
                  state     <= S_DONE;
                end else begin
                  state <= S_FILL;
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          idx <= idx + IDXW'(1);
          if (idx == IDXW'(hss_pkg::ALPHABET - 1)) begin
            state <= (pat_cnt > PCW'(1)) ? S_BLD_RD : S_CMP_RD;
          end
        end
        S_BLD_RD: state <= S_BLD_WR;
        S_BLD_WR: begin
          idx   <= idx + IDXW'(1);
          state <= bld_more ? S_BLD_RD : S_CMP_RD;
        end
        S_CMP_RD: state <= S_CMP_CHK;
        S_CMP_CHK: begin
          if (txt_rdata == pat_rdata) begin
            if (k == PCW'(1)) begin
              res_found <= 1'b1;
              state     <= S_DONE;
            end else begin
              k     <= k_dec;
              state <= S_CMP_RD;
            end
          end else begin
            state <= S_SKP_RD;
          end
        end
        S_SKP_RD: state <= S_SKP_LK;
        S_SKP_LK: state <= S_SKP_ADV;
        S_SKP_ADV: begin
          at <= at_adv;
          k  <= pat_cnt;
          if (adv_ok) begin
            state <= S_CMP_RD;
          end else begin
            res_found <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the result register is free, then clear both byte counts and the flag.
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= res_found;
            position  <= res_found ? hss_pkg::POS_W'(at) : '0;
            overflow  <= ovf_flag;
            pat_cnt   <= '0;
            txt_cnt   <= '0;
            ovf_flag  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HSS_ASSERT_NOW(a_k_live, clk, rst, state == S_CMP_CHK, k != '0, "compare with empty suffix")
  `HSS_ASSERT_NOW(a_window_in, clk, rst, state == S_CMP_RD, (at + m_sw) <= n_sw, "window past text end")
  `HSS_ASSERT_NEXT(a_search_busy, clk, rst, in_fire && (action == hss_pkg::ACT_SEARCH), !in_ready, "search request did not stall input")
  `HSS_ASSERT_NEXT(a_done_clear, clk, rst, (state == S_DONE) && out_free, (pat_cnt == '0) && (txt_cnt == '0) && !ovf_flag && out_valid, "stores not emptied after result")

endmodule
